[rtl/bps_pkg.sv]
`timescale 1ns / 1ps
// bps_pkg: word types, function codes and status codes for the pattern search block.
// Self-contained; imported by every module of the block.
package bps_pkg;

    localparam logic [1:0] FUNC_CLEAR  = 2'd0;
    localparam logic [1:0] FUNC_APPEND = 2'd1;
    localparam logic [1:0] FUNC_TEXT   = 2'd2;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_TRUNC = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] data_byte;
        logic       last;
    } in_word_t;

    typedef struct packed {
        logic       found;
        logic [1:0] status;
    } out_word_t;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_TEXT   = 2'd2
    } op_kind_t;

    typedef struct packed {
        op_kind_t   kind;
        logic [7:0] data_byte;
        logic       last;
    } op_t;

endpackage

[rtl/binary_pattern_search.sv]
`timescale 1ns / 1ps
// Pattern search over a byte stream.
// Input queue side: push/full with word item (func, data_byte, last). A word is taken
// at a clock edge with push high and full low. func selects clear, pattern append or
// text byte; the unused code is dropped.
// Result queue side: empty/pop with word result (found, status). The oldest result is
// shown while empty is low and is taken at an edge with pop high and empty low.
// One result is produced for each text byte marked last.
// Throughput: one word per cycle while full stays low; the back end compares the text
// window against the whole pattern at once.
// A text byte passes the input register and then the operation queue; the back end
// writes its result into the result queue.
// Reset empties both queues, the pattern and the search state.
// When pop is held low the result queue fills, the back end halts, then the
// operation queue and finally full rises; no word is lost.
// Depends on bps_pkg, bps_front, bps_fifo and bps_back.
module binary_pattern_search
    import bps_pkg::*;
#(
    parameter int PATTERN_MAX = 64
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  in_word_t  item,
    output logic      full,
    input  logic      pop,
    output out_word_t result,
    output logic      empty
);

    logic      op_push, op_full, op_empty, op_pop;
    op_t       op_in, op_out;
    logic      res_push, res_full;
    out_word_t res_in;

    bps_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .item    (item),
        .full    (full),
        .op_push (op_push),
        .op      (op_in),
        .op_full (op_full)
    );

    bps_fifo #(
        .T     (op_t),
        .DEPTH (2)
    ) u_op_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (op_push),
        .din   (op_in),
        .full  (op_full),
        .pop   (op_pop),
        .dout  (op_out),
        .empty (op_empty)
    );

    bps_back #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .op_empty (op_empty),
        .op       (op_out),
        .op_pop   (op_pop),
        .res_push (res_push),
        .res      (res_in),
        .res_full (res_full)
    );

    bps_fifo #(
        .T     (out_word_t),
        .DEPTH (2)
    ) u_res_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .din   (res_in),
        .full  (res_full),
        .pop   (pop),
        .dout  (result),
        .empty (empty)
    );

endmodule

[rtl/bps_fifo.sv]
`timescale 1ns / 1ps
// bps_fifo: small register queue with push/full and pop/empty sides.
// Uses bps_pkg types through its type parameter.
module bps_fifo
    import bps_pkg::*;
#(
    parameter type T     = op_t,
    parameter int  DEPTH = 2
) (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  T     din,
    output logic full,
    input  logic pop,
    output T     dout,
    output logic empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    T                 mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

[rtl/bps_front.sv]
`timescale 1ns / 1ps
// bps_front: input stage; registers each word and decodes it into an operation, dropping the unused code.
// Depends on bps_pkg.
module bps_front
    import bps_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  in_word_t item,
    output logic     full,
    output logic     op_push,
    output op_t      op,
    input  logic     op_full
);

    logic valid_reg, valid_next;
    op_t  op_reg, op_next;
    logic ready;
    logic keep;

    assign ready   = !valid_reg || !op_full;
    assign full    = !ready;
    assign op_push = valid_reg;
    assign op      = op_reg;

    always_comb
    begin
        keep              = 1'b1;
        op_next.data_byte = item.data_byte;
        op_next.last      = 1'b0;
        unique case (item.func)
            FUNC_CLEAR:  op_next.kind = OP_CLEAR;
            FUNC_APPEND: op_next.kind = OP_APPEND;
            FUNC_TEXT:
            begin
                op_next.kind = OP_TEXT;
                op_next.last = item.last;
            end
            default:
            begin
                op_next.kind = OP_CLEAR;
                keep         = 1'b0;
            end
        endcase
        valid_next = ready ? (push && keep) : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready && push)
        begin
            op_reg <= op_next;
        end
    end

endmodule

[rtl/bps_back.sv]
`timescale 1ns / 1ps
// bps_back: pattern and text window shift registers with parallel compare.
// Depends on bps_pkg.
module bps_back
    import bps_pkg::*;
#(
    parameter int PATTERN_MAX = 64
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      op_empty,
    input  op_t       op,
    output logic      op_pop,
    output logic      res_push,
    output out_word_t res,
    input  logic      res_full
);

    localparam int LEN_W = $clog2(PATTERN_MAX + 1);

    // Pattern is kept right-aligned against the newest window byte.
    logic [7:0]       pat_reg  [PATTERN_MAX];
    logic [7:0]       pat_next [PATTERN_MAX];
    logic [7:0]       win_reg  [PATTERN_MAX];
    logic [7:0]       win_next [PATTERN_MAX];
    logic [LEN_W-1:0] len_reg, len_next;
    logic [LEN_W-1:0] seen_reg, seen_next;
    logic             match_reg, match_next;
    logic             trunc_reg, trunc_next;
    logic [PATTERN_MAX-1:0] hit;
    logic             go;
    logic             match_now;
    logic             len_full;

    assign go       = !op_empty && !res_full;
    assign op_pop   = go;
    assign len_full = (len_reg == LEN_W'(PATTERN_MAX));

    always_comb
    begin
        for (int j = 0; j < PATTERN_MAX - 1; j++)
        begin
            win_next[j] = win_reg[j + 1];
            pat_next[j] = pat_reg[j + 1];
        end
        win_next[PATTERN_MAX - 1] = op.data_byte;
        pat_next[PATTERN_MAX - 1] = op.data_byte;
    end

    always_comb
    begin
        for (int j = 0; j < PATTERN_MAX; j++)
        begin
            hit[j] = (({1'b0, len_reg} + (LEN_W + 1)'(j)) < (LEN_W + 1)'(PATTERN_MAX))
                     || (win_next[j] == pat_reg[j]);
        end
    end

    always_comb
    begin
        len_next   = len_reg;
        trunc_next = trunc_reg;
        seen_next  = seen_reg;
        match_next = match_reg;
        match_now  = 1'b0;
        res_push   = 1'b0;
        res.found  = 1'b0;
        res.status = STATUS_OK;
        if (go)
        begin
            unique case (op.kind)
                OP_CLEAR:
                begin
                    len_next   = '0;
                    trunc_next = 1'b0;
                    seen_next  = '0;
                    match_next = 1'b0;
                end
                OP_APPEND:
                begin
                    if (len_full)
                    begin
                        trunc_next = 1'b1;
                    end
                    else
                    begin
                        len_next = len_reg + LEN_W'(1);
                    end
                end
                OP_TEXT:
                begin
                    seen_next = (seen_reg == LEN_W'(PATTERN_MAX)) ? seen_reg
                                                                  : seen_reg + LEN_W'(1);
                    match_now = (len_reg != '0) && (seen_next >= len_reg) && (&hit);
                    match_next = match_reg || match_now;
                    if (op.last)
                    begin
                        res_push = 1'b1;
                        if (len_reg == '0)
                        begin
                            res.status = STATUS_EMPTY;
                        end
                        else
                        begin
                            res.found  = match_next;
                            res.status = trunc_reg ? STATUS_TRUNC : STATUS_OK;
                        end
                        seen_next  = '0;
                        match_next = 1'b0;
                    end
                end
                default:
                begin
                    len_next = len_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg   <= '0;
            seen_reg  <= '0;
            match_reg <= 1'b0;
            trunc_reg <= 1'b0;
        end
        else
        begin
            len_reg   <= len_next;
            seen_reg  <= seen_next;
            match_reg <= match_next;
            trunc_reg <= trunc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go && (op.kind == OP_TEXT))
        begin
            win_reg <= win_next;
        end
        if (go && (op.kind == OP_APPEND) && !len_full)
        begin
            pat_reg <= pat_next;
        end
    end

endmodule

[bench/tb_binary_pattern_search.sv]
`timescale 1ns / 1ps
// tb_binary_pattern_search: self-checking bench for the byte pattern search block.
// Depends on bps_pkg and binary_pattern_search; expected words come from a local predictor.
module tb_binary_pattern_search;
    import bps_pkg::*;

    localparam int PATTERN_MAX = 64;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam int TARGET_WORDS = 750;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 12;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic push = 1'b0;
    in_word_t item = '0;
    logic full;
    logic pop = 1'b0;
    out_word_t result;
    logic empty;

    // predictor state
    logic [7:0] pat_bytes [PATTERN_MAX];
    int unsigned pat_len = 0;
    logic [7:0] win_bytes [PATTERN_MAX];
    int unsigned seen_cnt = 0;
    bit hit_flag = 1'b0;
    bit pat_trunc = 1'b0;

    out_word_t expected_results [$];
    int unsigned error_count = 0;
    int unsigned result_count = 0;
    int unsigned word_count = 0;
    int unsigned cycle_count = 0;
    int unsigned burst_left = 0;
    int unsigned stall_left = 0;
    bit sender_idles = 1'b1;

    binary_pattern_search #(
        .PATTERN_MAX(PATTERN_MAX)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .item  (item),
        .full  (full),
        .pop   (pop),
        .result(result),
        .empty (empty)
    );

    always #5ns clk = ~clk;

    function automatic void clear_search();
        foreach (win_bytes[i])
            win_bytes[i] = 8'h00;
        seen_cnt = 0;
        hit_flag = 1'b0;
    endfunction

    function automatic bit window_hit();
        int unsigned base;
        base = PATTERN_MAX - pat_len;
        for (int unsigned i = 0; i < pat_len; i++)
            if (win_bytes[base + i] != pat_bytes[i])
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic void predict_word(input in_word_t w);
        out_word_t r;
        case (w.func)
            FUNC_CLEAR:
            begin
                pat_len = 0;
                pat_trunc = 1'b0;
                clear_search();
            end
            FUNC_APPEND:
            begin
                if (pat_len < PATTERN_MAX)
                begin
                    pat_bytes[pat_len] = w.data_byte;
                    pat_len++;
                end
                else
                    pat_trunc = 1'b1;
            end
            FUNC_TEXT:
            begin
                for (int i = 0; i < PATTERN_MAX - 1; i++)
                    win_bytes[i] = win_bytes[i + 1];
                win_bytes[PATTERN_MAX - 1] = w.data_byte;
                if (seen_cnt < PATTERN_MAX)
                    seen_cnt++;
                if (pat_len > 0 && seen_cnt >= pat_len && window_hit())
                    hit_flag = 1'b1;
                if (w.last)
                begin
                    if (pat_len == 0)
                    begin
                        r.found = 1'b0;
                        r.status = STATUS_EMPTY;
                    end
                    else
                    begin
                        r.found = hit_flag;
                        r.status = pat_trunc ? STATUS_TRUNC : STATUS_OK;
                    end
                    expected_results = {expected_results, r};
                    clear_search();
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got_v,
                                   input int unsigned want_v);
        $display("mismatch on result word %0d, %s: got %0d, expected %0d",
                 result_count, what, got_v, want_v);
        error_count++;
    endtask

    task automatic check_result(input out_word_t got);
        out_word_t want;
        result_count++;
        if (expected_results.size() == 0)
            report_mismatch("word with none expected, found", 32'(got.found), 0);
        else
        begin
            want = expected_results.pop_front();
            if (got.found !== want.found)
                report_mismatch("found", 32'(got.found), 32'(want.found));
            if (got.status !== want.status)
                report_mismatch("status", 32'(got.status), 32'(want.status));
        end
    endtask

    // sender: bursts of random length, with random gaps between some of them
    task automatic send_word(input in_word_t w);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = (sender_idles && $urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0;
            if (gap > 0)
            begin
                push <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        push <= 1'b1;
        item <= w;
        @(posedge clk);
        while (full)
            @(posedge clk);
        predict_word(w);
        burst_left--;
        if (w.func != FUNC_UNUSED)
            word_count++;
    endtask

    task automatic send_op(input op_kind_t kind, input logic [7:0] value, input logic is_last);
        in_word_t w;
        w.func = kind;
        w.data_byte = value;
        w.last = is_last;
        send_word(w);
    endtask

    task automatic send_unused(input logic [7:0] value, input logic is_last);
        in_word_t w;
        w.func = FUNC_UNUSED;
        w.data_byte = value;
        w.last = is_last;
        send_word(w);
    endtask

    task automatic test_empty_pattern();
        send_op(OP_TEXT, 8'h00, 1'b0);
        send_op(OP_TEXT, 8'hFF, 1'b1);
    endtask

    task automatic test_ignored_words();
        send_unused(8'hFF, 1'b1);
        send_op(OP_APPEND, 8'hA5, 1'b1);
        send_op(OP_CLEAR, 8'hFF, 1'b1);
        send_op(OP_TEXT, 8'hA5, 1'b1);
    endtask

    task automatic test_short_text();
        send_op(OP_CLEAR, 8'h00, 1'b0);
        send_op(OP_APPEND, 8'h00, 1'b0);
        send_op(OP_APPEND, 8'hFF, 1'b0);
        send_op(OP_APPEND, 8'h00, 1'b0);
        send_op(OP_TEXT, 8'h00, 1'b0);
        send_op(OP_TEXT, 8'hFF, 1'b1);
    endtask

    // pattern grows mid-stream; match only through the longer pattern
    task automatic test_append_in_stream();
        send_op(OP_CLEAR, 8'h00, 1'b0);
        send_op(OP_APPEND, 8'h3C, 1'b0);
        send_op(OP_TEXT, 8'h11, 1'b0);
        send_op(OP_APPEND, 8'h5A, 1'b0);
        send_op(OP_TEXT, 8'h3C, 1'b0);
        send_op(OP_TEXT, 8'h5A, 1'b1);
        send_op(OP_TEXT, 8'h3C, 1'b1);
    endtask

    task automatic test_random_streams();
        logic [7:0] alpha [4];
        logic [7:0] pat [$];
        logic [7:0] txt [$];
        logic [7:0] b;
        int unsigned alpha_n;
        int unsigned plen;
        int unsigned tlen;
        int unsigned spot;
        bit abandoned;
        while (word_count < TARGET_WORDS)
        begin
            sender_idles = ($urandom_range(0, 3) != 0);
            foreach (alpha[i])
                alpha[i] = 8'($urandom_range(0, 255));
            alpha_n = $urandom_range(1, 4);
            if (pat.size() == 0 || $urandom_range(0, 9) < 7)
            begin
                send_op(OP_CLEAR, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                plen = ($urandom_range(0, 14) == 0) ? $urandom_range(60, 70)
                                                    : $urandom_range(0, 6);
                pat.delete();
                for (int i = 0; i < plen; i++)
                begin
                    b = alpha[$urandom_range(0, alpha_n - 1)];
                    if (pat.size() < PATTERN_MAX)
                        pat = {pat, b};
                    send_op(OP_APPEND, b, 1'($urandom_range(0, 1)));
                end
            end
            tlen = (pat.size() > 16) ? $urandom_range(40, 90) : $urandom_range(1, 16);
            txt.delete();
            for (int i = 0; i < tlen; i++)
                txt = {txt, alpha[$urandom_range(0, alpha_n - 1)]};
            if ($urandom_range(0, 1) == 1 && pat.size() > 0 && pat.size() <= tlen)
            begin
                spot = $urandom_range(0, tlen - pat.size());
                foreach (pat[i])
                    txt[spot + i] = pat[i];
            end
            abandoned = 1'b0;
            for (int i = 0; i < tlen && !abandoned; i++)
            begin
                case ($urandom_range(0, 59))
                    0: send_unused(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                    1:
                    begin
                        b = alpha[$urandom_range(0, alpha_n - 1)];
                        if (pat.size() < PATTERN_MAX)
                            pat = {pat, b};
                        send_op(OP_APPEND, b, 1'b0);
                    end
                    2:
                    begin
                        send_op(OP_CLEAR, 8'($urandom_range(0, 255)), 1'b0);
                        pat.delete();
                        abandoned = 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
                if (!abandoned)
                    send_op(OP_TEXT, txt[i], i == tlen - 1);
            end
        end
    endtask

    // receiver: steps through three stall patterns in turn: none, short stalls, rare long stalls
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pop && !empty)
                check_result(result);
            if (stall_left > 0)
            begin
                pop <= 1'b0;
                stall_left--;
            end
            else
            begin
                pop <= 1'b1;
                case ((cycle_count / 500) % 3)
                    0: stall_left = 0;
                    1: stall_left = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
                    default:
                        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 24) : 0;
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d words outstanding",
                     cycle_count, expected_results.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        clear_search();
        foreach (pat_bytes[i])
            pat_bytes[i] = 8'h00;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        test_empty_pattern();
        test_ignored_words();
        test_short_text();
        test_append_in_stream();
        test_random_streams();
        push <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

[filelist.f]
rtl/bps_pkg.sv
rtl/bps_fifo.sv
rtl/bps_front.sv
rtl/bps_back.sv
rtl/binary_pattern_search.sv
bench/tb_binary_pattern_search.sv
